@@ rtl/epf_pkg.sv @@
package epf_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef enum logic [1:0] {
        CFG_ESCAPE = 2'd0,
        CFG_START  = 2'd1,
        CFG_END    = 2'd2,
        CFG_FLAGS  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        ACT_HEADER = 1'b0,
        ACT_DATA   = 1'b1
    } t_action;

    typedef enum logic [3:0] {
        SL_IDLE,
        SL_SOP_ESC,
        SL_SOP_CHAR,
        SL_ID,
        SL_FLAGS,
        SL_LEN,
        SL_DATA,
        SL_SUM_LO,
        SL_SUM_HI,
        SL_EOP_ESC,
        SL_EOP_CHAR
    } t_slot;

    typedef struct packed {
        t_action     kind;
        logic [7:0]  first;
        logic [7:0]  flags;
        logic [7:0]  len;
        logic        trailer;
        logic [15:0] sum;
    } t_cmd;

    typedef struct packed {
        logic [7:0] esc;
        logic [7:0] sop;
        logic [7:0] eop;
    } t_frame_cfg;

endpackage

@@ rtl/epf_front.sv @@
module epf_front import epf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic [7:0] i_message_id,
    input  logic [7:0] i_payload_length,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_flags,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic        r_in_frame, n_in_frame;
    logic [7:0]  r_left, n_left;
    logic [15:0] r_sum, n_sum;

    logic        accept;
    logic        is_header;
    logic [15:0] hdr_sum;
    logic [15:0] data_sum;
    logic [7:0]  left_dec;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign is_header  = (t_action'(i_action) == ACT_HEADER);
    assign hdr_sum    = {8'd0, i_message_id} + {8'd0, i_flags} + {8'd0, i_payload_length};
    assign data_sum   = r_sum + {8'd0, i_data_byte};
    assign left_dec   = r_left - 8'd1;

    always_comb begin
        o_push     = accept && (is_header || r_in_frame);
        o_cmd      = '0;
        n_in_frame = r_in_frame;
        n_left     = r_left;
        n_sum      = r_sum;
        if (is_header) begin
            o_cmd.kind    = ACT_HEADER;
            o_cmd.first   = i_message_id;
            o_cmd.flags   = i_flags;
            o_cmd.len     = i_payload_length;
            o_cmd.trailer = (i_payload_length == 8'd0);
            o_cmd.sum     = hdr_sum;
        end else begin
            o_cmd.kind    = ACT_DATA;
            o_cmd.first   = i_data_byte;
            o_cmd.flags   = i_flags;
            o_cmd.len     = r_left;
            o_cmd.trailer = (left_dec == 8'd0);
            o_cmd.sum     = data_sum;
        end
        if (accept) begin
            if (is_header) begin
                if (i_payload_length == 8'd0) begin
                    n_in_frame = 1'b0;
                    n_left     = 8'd0;
                    n_sum      = 16'd0;
                end else begin
                    n_in_frame = 1'b1;
                    n_left     = i_payload_length;
                    n_sum      = hdr_sum;
                end
            end else if (r_in_frame) begin
                if (left_dec == 8'd0) begin
                    n_in_frame = 1'b0;
                    n_left     = 8'd0;
                    n_sum      = 16'd0;
                end else begin
                    n_left = left_dec;
                    n_sum  = data_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_left     <= 8'd0;
            r_sum      <= 16'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_left     <= n_left;
            r_sum      <= n_sum;
        end
    end

endmodule

@@ rtl/epf_queue.sv @@
module epf_queue import epf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_head_valid,
    output t_cmd o_head
);

    t_cmd           r_mem [QDepth];
    logic [QAw-1:0] r_wr_ptr;
    logic [QAw-1:0] r_rd_ptr;
    logic [QAw:0]   r_count;

    assign o_full       = (r_count == (QAw+1)'(QDepth));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAw'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAw'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QAw+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QAw+1)'(1);
            end
        end
    end

endmodule

@@ rtl/epf_back.sv @@
module epf_back import epf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_frame_cfg i_cfg,
    input  logic       i_head_valid,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end
);

    t_slot      r_slot, n_slot;
    logic       r_esc_sent, n_esc_sent;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_frame_end;

    t_slot      cur;
    t_slot      nxt;
    logic [7:0] slot_byte;
    logic       stuffable;
    logic       slot_end;
    logic       insert_esc;
    logic       load;
    logic       work;

    assign load = !r_out_valid || i_out_ready;
    assign work = i_head_valid && load;

    always_comb begin
        if (r_slot == SL_IDLE) begin
            cur = (i_head.kind == ACT_HEADER) ? SL_SOP_ESC : SL_DATA;
        end else begin
            cur = r_slot;
        end
        slot_byte = i_cfg.esc;
        stuffable = 1'b0;
        slot_end  = 1'b0;
        nxt       = SL_IDLE;
        case (cur)
            SL_SOP_ESC: begin
                slot_byte = i_cfg.esc;
                nxt       = SL_SOP_CHAR;
            end
            SL_SOP_CHAR: begin
                slot_byte = i_cfg.sop;
                nxt       = SL_ID;
            end
            SL_ID: begin
                slot_byte = i_head.first;
                stuffable = 1'b1;
                nxt       = SL_FLAGS;
            end
            SL_FLAGS: begin
                slot_byte = i_head.flags;
                stuffable = 1'b1;
                nxt       = SL_LEN;
            end
            SL_LEN: begin
                slot_byte = i_head.len;
                stuffable = 1'b1;
                nxt       = i_head.trailer ? SL_SUM_LO : SL_IDLE;
            end
            SL_DATA: begin
                slot_byte = i_head.first;
                stuffable = 1'b1;
                nxt       = i_head.trailer ? SL_SUM_LO : SL_IDLE;
            end
            SL_SUM_LO: begin
                slot_byte = i_head.sum[7:0];
                stuffable = 1'b1;
                nxt       = SL_SUM_HI;
            end
            SL_SUM_HI: begin
                slot_byte = i_head.sum[15:8];
                stuffable = 1'b1;
                nxt       = SL_EOP_ESC;
            end
            SL_EOP_ESC: begin
                slot_byte = i_cfg.esc;
                nxt       = SL_EOP_CHAR;
            end
            SL_EOP_CHAR: begin
                slot_byte = i_cfg.eop;
                slot_end  = 1'b1;
                nxt       = SL_IDLE;
            end
            default: begin
                nxt = SL_IDLE;
            end
        endcase

        insert_esc = stuffable && (slot_byte == i_cfg.esc) && !r_esc_sent;
        o_pop      = work && !insert_esc && (nxt == SL_IDLE);

        n_slot     = r_slot;
        n_esc_sent = r_esc_sent;
        if (work) begin
            n_esc_sent = insert_esc;
            n_slot     = insert_esc ? cur : nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= SL_IDLE;
            r_esc_sent <= 1'b0;
        end else begin
            r_slot     <= n_slot;
            r_esc_sent <= n_esc_sent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_out_byte  <= insert_esc ? i_cfg.esc : slot_byte;
            r_frame_end <= insert_esc ? 1'b0 : slot_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_frame_end = r_frame_end;

endmodule

@@ rtl/escaped_packet_framer.sv @@
// Byte-stuffing frame builder. Items enter through a four-entry command queue at up to one
// transfer per cycle while the queue is not full, and a serializer sends one framed byte per
// cycle from a registered output while the receiver is ready. A payload byte that equals the
// escape value is sent after an added escape byte; a header goes out as five to eight bytes,
// and the closing sum and end pair add four to six more. The sustained rate is therefore set
// by the serializer, with the queue absorbing header bursts. The flags register is captured
// when the header is taken; the escape, start and end registers are read as each byte leaves.
module escaped_packet_framer import epf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic [7:0] i_message_id,
    input  logic [7:0] i_payload_length,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_escape;
    logic [7:0] r_start;
    logic [7:0] r_end;
    logic [7:0] r_flags;

    t_frame_cfg frame_cfg;
    logic       q_full;
    logic       push;
    t_cmd       push_cmd;
    logic       pop;
    logic       head_valid;
    t_cmd       head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= 8'd16;
            r_start  <= 8'd2;
            r_end    <= 8'd3;
            r_flags  <= 8'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ESCAPE: r_escape <= i_cfg_data;
                CFG_START:  r_start  <= i_cfg_data;
                CFG_END:    r_end    <= i_cfg_data;
                CFG_FLAGS:  r_flags  <= i_cfg_data;
                default:    r_flags  <= r_flags;
            endcase
        end
    end

    assign frame_cfg.esc = r_escape;
    assign frame_cfg.sop = r_start;
    assign frame_cfg.eop = r_end;

    epf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_message_id     (i_message_id),
        .i_payload_length (i_payload_length),
        .i_data_byte      (i_data_byte),
        .i_flags          (r_flags),
        .i_q_full         (q_full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    epf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    epf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (frame_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_frame_end  (o_frame_end)
    );

endmodule

@@ rtl/epf_checker.sv @@
module epf_checker import epf_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_frame_end,
    input logic       i_cfg_we,
    input logic [1:0] i_cfg_index,
    input logic [7:0] i_cfg_data
);

    logic [7:0] r_escape;
    logic [7:0] r_end;
    logic [7:0] r_prev_byte;
    logic       out_xfer;

    assign out_xfer = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape    <= 8'd16;
            r_end       <= 8'd3;
            r_prev_byte <= 8'd0;
        end else begin
            if (i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_ESCAPE)) begin
                r_escape <= i_cfg_data;
            end
            if (i_cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_END)) begin
                r_end <= i_cfg_data;
            end
            if (out_xfer) begin
                r_prev_byte <= o_out_byte;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_frame_end))
        else $error("Output changed while a transfer was stalled.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_end_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_out_byte == r_end)
        else $error("Frame end marker on a byte other than the end character.");

    a_end_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && o_frame_end |-> r_prev_byte == r_escape)
        else $error("End character not preceded by the escape byte.");

endmodule

bind escaped_packet_framer epf_checker u_epf_checker (.*);
